/* src/tsd_pkg.sv */
// Package for the tar stream deframer: payload structs, codes and constants.
// Used by every module under src.
package tsd_pkg;

    localparam int SIZE_WIDTH = 36;
    localparam int MODE_WIDTH = 24;
    localparam int BLOCK_BYTES = 512;
    localparam int OFF_WIDTH = 9;

    localparam logic [OFF_WIDTH-1:0] OFF_MODE = 9'd100;
    localparam logic [OFF_WIDTH-1:0] OFF_MODE_END = 9'd108;
    localparam logic [OFF_WIDTH-1:0] OFF_SIZE = 9'd124;
    localparam logic [OFF_WIDTH-1:0] OFF_SIZE_END = 9'd136;
    localparam logic [OFF_WIDTH-1:0] OFF_TYPE = 9'd156;
    localparam logic [OFF_WIDTH-1:0] OFF_LINK = 9'd157;
    localparam logic [OFF_WIDTH-1:0] OFF_LAST = 9'(BLOCK_BYTES - 1);

    localparam logic [1:0] RK_DATA = 2'd0;
    localparam logic [1:0] RK_HEADER = 2'd1;
    localparam logic [1:0] RK_END = 2'd2;
    localparam logic [1:0] RK_ERROR = 2'd3;

    localparam logic [2:0] EK_REGULAR = 3'd0;
    localparam logic [2:0] EK_DIR = 3'd1;
    localparam logic [2:0] EK_SYMLINK = 3'd2;
    localparam logic [2:0] EK_HARDLINK = 3'd3;
    localparam logic [2:0] EK_OTHER = 3'd4;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_EOF = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH = 1;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [7:0]            data_byte;
        logic                  last_data;
        logic [2:0]            entry_kind;
        logic [7:0]            other_kind_code;
        logic [SIZE_WIDTH-1:0] entry_size;
        logic [MODE_WIDTH-1:0] entry_mode;
        logic                  has_link_target;
        logic [1:0]            error_code;
    } out_item_t;

endpackage

/* src/tar_stream_deframer.sv */
// Tar stream deframer top level: front parser, result queue, output register.
// A result is written into the queue and then loaded into the output register.
// Throughput: one byte per cycle; a full two-entry queue stalls the input.
// Reset: asynchronous, active low; returns to the header phase at offset 0.
// Depends on tsd_pkg, tsd_front, tsd_queue, tsd_back.
module tar_stream_deframer
    import tsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_item_t  in_data,
    output logic      in_stall,
    output logic      out_valid,
    output out_item_t out_data,
    input  logic      out_stall
);

    logic      req_valid, req_full, q_valid, q_take;
    out_item_t req_item, q_item;

    tsd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_item(in_data),
        .in_stall(in_stall), .req_valid(req_valid), .req_item(req_item),
        .req_full(req_full)
    );

    tsd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(req_valid), .wr_item(req_item),
        .full(req_full), .rd_valid(q_valid), .rd_item(q_item), .rd_take(q_take)
    );

    tsd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .out_valid(out_valid), .out_item(out_data),
        .out_stall(out_stall)
    );

endmodule

/* src/tsd_front.sv */
// Front part: accepts archive bytes, walks the block structure and parses headers.
// Emits one classified result request per byte that yields one. Depends on tsd_pkg.
module tsd_front
    import tsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_item_t  in_item,
    output logic      in_stall,
    output logic      req_valid,
    output out_item_t req_item,
    input  logic      req_full
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_DATA, PH_PAD, PH_ZERO2, PH_END, PH_ERR_HDR, PH_ERR_EOF
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [OFF_WIDTH-1:0]  off_reg, off_next;
    logic                  nz_reg, nz_next;
    logic [SIZE_WIDTH-1:0] size_reg, size_next;
    logic [MODE_WIDTH-1:0] mode_reg, mode_next;
    logic [1:0]            oct_reg, oct_next;
    logic                  bad_reg, bad_next;
    logic [7:0]            tflag_reg, tflag_next;
    logic                  link_reg, link_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;
    logic [OFF_WIDTH-1:0]  pad_reg, pad_next;

    logic       take;
    logic [7:0] b;
    logic       blank, digit;
    logic [2:0] dval;
    logic [1:0] oct_cur;

    assign in_stall = req_full;
    assign take = in_valid && !req_full;
    assign b = in_item.stream_byte;
    assign blank = (b == 8'd0) || (b == 8'd32);
    assign digit = (b >= 8'd48) && (b <= 8'd55);
    assign dval = b[2:0];

    always_comb
    begin
        phase_next = phase_reg;
        off_next = off_reg;
        nz_next = nz_reg;
        size_next = size_reg;
        mode_next = mode_reg;
        oct_next = oct_reg;
        bad_next = bad_reg;
        tflag_next = tflag_reg;
        link_next = link_reg;
        left_next = left_reg;
        pad_next = pad_reg;
        req_valid = 1'b0;
        req_item = '0;
        oct_cur = oct_reg;

        if (take)
        begin
            if (phase_reg == PH_ERR_HDR || phase_reg == PH_ERR_EOF)
            begin
                req_valid = 1'b1;
                req_item.result_kind = RK_ERROR;
                req_item.error_code = (phase_reg == PH_ERR_HDR) ? ERR_HEADER : ERR_EOF;
            end
            else if (phase_reg == PH_END)
            begin
                // ignore everything after the archive end
            end
            else if (in_item.end_marker)
            begin
                if (!(phase_reg == PH_HEADER && off_reg == '0))
                begin
                    phase_next = PH_ERR_EOF;
                    req_valid = 1'b1;
                    req_item.result_kind = RK_ERROR;
                    req_item.error_code = ERR_EOF;
                end
            end
            else if (phase_reg == PH_DATA)
            begin
                req_valid = 1'b1;
                req_item.result_kind = RK_DATA;
                req_item.data_byte = b;
                left_next = left_reg - 1'b1;
                if (left_next == '0)
                begin
                    req_item.last_data = 1'b1;
                    phase_next = (pad_reg != '0) ? PH_PAD : PH_HEADER;
                end
            end
            else if (phase_reg == PH_PAD)
            begin
                pad_next = pad_reg - 1'b1;
                if (pad_next == '0)
                    phase_next = PH_HEADER;
            end
            else
            begin
                if (b != 8'd0)
                    nz_next = 1'b1;
                if (phase_reg == PH_HEADER)
                begin
                    if (off_reg == OFF_MODE || off_reg == OFF_SIZE)
                        oct_cur = 2'd0;
                    oct_next = oct_cur;
                    if ((off_reg >= OFF_MODE && off_reg < OFF_MODE_END)
                        || (off_reg >= OFF_SIZE && off_reg < OFF_SIZE_END))
                    begin
                        if (oct_cur < 2'd2 && !(oct_cur == 2'd0 && blank))
                        begin
                            if (blank)
                                oct_next = 2'd2;
                            else if (digit)
                            begin
                                oct_next = 2'd1;
                                if (off_reg < OFF_MODE_END)
                                    mode_next = {mode_reg[MODE_WIDTH-4:0], dval};
                                else
                                    size_next = {size_reg[SIZE_WIDTH-4:0], dval};
                            end
                            else
                            begin
                                bad_next = 1'b1;
                                oct_next = 2'd2;
                            end
                        end
                    end
                    else if (off_reg == OFF_TYPE)
                        tflag_next = b;
                    else if (off_reg == OFF_LINK)
                        link_next = (b != 8'd0);
                end

                if (off_reg != OFF_LAST)
                    off_next = off_reg + 1'b1;
                else
                begin
                    off_next = '0;
                    size_next = '0;
                    mode_next = '0;
                    oct_next = 2'd0;
                    bad_next = 1'b0;
                    tflag_next = 8'd0;
                    link_next = 1'b0;
                    nz_next = 1'b0;
                    if (phase_reg == PH_ZERO2)
                    begin
                        req_valid = 1'b1;
                        if (nz_next == 1'b0 && (nz_reg || b != 8'd0))
                        begin
                            phase_next = PH_ERR_HDR;
                            req_item.result_kind = RK_ERROR;
                            req_item.error_code = ERR_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_END;
                            req_item.result_kind = RK_END;
                        end
                    end
                    else if (!(nz_reg || b != 8'd0))
                        phase_next = PH_ZERO2;
                    else if (bad_reg)
                    begin
                        phase_next = PH_ERR_HDR;
                        req_valid = 1'b1;
                        req_item.result_kind = RK_ERROR;
                        req_item.error_code = ERR_HEADER;
                    end
                    else
                    begin
                        req_valid = 1'b1;
                        req_item.result_kind = RK_HEADER;
                        case (tflag_reg)
                            8'd0, 8'd48: req_item.entry_kind = EK_REGULAR;
                            8'd53:       req_item.entry_kind = EK_DIR;
                            8'd50:       req_item.entry_kind = EK_SYMLINK;
                            8'd49:       req_item.entry_kind = EK_HARDLINK;
                            default:
                            begin
                                req_item.entry_kind = EK_OTHER;
                                req_item.other_kind_code = tflag_reg;
                            end
                        endcase
                        req_item.entry_size = size_reg;
                        req_item.entry_mode = mode_reg;
                        req_item.has_link_target = link_reg;
                        left_next = size_reg;
                        pad_next = OFF_WIDTH'(-size_reg[OFF_WIDTH-1:0]);
                        if (size_reg != '0)
                            phase_next = PH_DATA;
                        else if (pad_next != '0)
                            phase_next = PH_PAD;
                        else
                            phase_next = PH_HEADER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            off_reg <= '0;
            nz_reg <= 1'b0;
            size_reg <= '0;
            mode_reg <= '0;
            oct_reg <= 2'd0;
            bad_reg <= 1'b0;
            tflag_reg <= 8'd0;
            link_reg <= 1'b0;
            left_reg <= '0;
            pad_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg <= off_next;
            nz_reg <= nz_next;
            size_reg <= size_next;
            mode_reg <= mode_next;
            oct_reg <= oct_next;
            bad_reg <= bad_next;
            tflag_reg <= tflag_next;
            link_reg <= link_next;
            left_reg <= left_next;
            pad_reg <= pad_next;
        end
    end

endmodule

/* src/tsd_queue.sv */
// Short result queue between the front and back parts.
// Two entries in flip-flops; depends on tsd_pkg.
module tsd_queue
    import tsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    input  out_item_t wr_item,
    output logic      full,
    output logic      rd_valid,
    output out_item_t rd_item,
    input  logic      rd_take
);

    out_item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]   wp_reg, rp_reg;
    logic [QPTR_WIDTH:0]     cnt_reg;
    logic                    wr, rd;

    assign full = (cnt_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item = mem_reg[rp_reg];
    assign wr = wr_valid && !full;
    assign rd = rd_take && rd_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_WIDTH+1)'(wr) - (QPTR_WIDTH+1)'(rd);
        end
    end

endmodule

/* src/tsd_back.sv */
// Back part: output register that presents queued results to the sink.
// Depends on tsd_pkg.
module tsd_back
    import tsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  out_item_t q_item,
    output logic      q_take,
    output logic      out_valid,
    output out_item_t out_item,
    input  logic      out_stall
);

    logic      valid_reg;
    out_item_t item_reg;

    // load when the register is empty or being drained
    assign q_take = q_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
            item_reg <= q_item;
    end

endmodule

/* src/tsd_checker.sv */
// Port-level checks for the tar stream deframer, bound to the top level.
// Depends on tsd_pkg.
module tsd_checker
    import tsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input out_item_t out_data,
    input logic      out_stall
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RK_ERROR |->
        out_data.error_code == ERR_HEADER || out_data.error_code == ERR_EOF)
        else $error("error result without code");

    a_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind != RK_ERROR |-> out_data.error_code == ERR_NONE)
        else $error("error code on non-error result");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_data |-> out_data.result_kind == RK_DATA)
        else $error("last flag on non-data result");

endmodule

bind tar_stream_deframer tsd_checker u_tsd_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tar_stream_deframer: directed rows, then a random archive.
// Depends on tsd_pkg and the tar_stream_deframer RTL.
module tb
    import tsd_pkg::*;
();

    typedef enum int {PH_HDR, PH_DAT, PH_PAD, PH_ZERO2, PH_END, PH_EHDR, PH_EEOF} phase_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       has_exp;
        out_item_t  exp;
    } row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    in_item_t  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    out_item_t out_data;
    logic      out_stall = 1'b0;

    // deframer model state
    phase_t                phase;
    int                    offset;
    bit                    nonzero;
    logic [SIZE_WIDTH-1:0] size_acc;
    logic [MODE_WIDTH-1:0] mode_acc;
    int                    oct_state;
    bit                    bad;
    logic [7:0]            tflag;
    bit                    link;
    logic [SIZE_WIDTH-1:0] remaining;
    logic [8:0]            pad_cnt;

    out_item_t expected_q[$];
    row_t      plan[$];
    int        errors = 0;
    longint    cycle = 0;
    bit        hold_off = 1'b0;
    bit        data_started = 1'b0;
    bit        sending_done = 1'b0;

    tar_stream_deframer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
        .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 3000000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void clear_header();
        offset = 0; nonzero = 0; size_acc = '0; mode_acc = '0;
        oct_state = 0; bad = 0; tflag = '0; link = 0;
    endfunction

    function automatic void deframer_reset();
        phase = PH_HDR;
        clear_header();
        remaining = '0;
        pad_cnt = '0;
    endfunction

    function automatic out_item_t make_item(logic [1:0] kind, logic [1:0] err);
        out_item_t r;
        r = '0;
        r.result_kind = kind;
        r.error_code = err;
        return r;
    endfunction

    function automatic void parse_octal(logic [7:0] b, bit is_size);
        if (oct_state >= 2)
            return;
        if (oct_state == 0 && (b == 8'h00 || b == 8'h20))
            return;
        if (b == 8'h00 || b == 8'h20)
            oct_state = 2;
        else if (b >= "0" && b <= "7")
        begin
            if (is_size)
                size_acc = (size_acc << 3) + SIZE_WIDTH'(b - "0");
            else
                mode_acc = (mode_acc << 3) + MODE_WIDTH'(b - "0");
            oct_state = 1;
        end
        else
        begin
            bad = 1;
            oct_state = 2;
        end
    endfunction

    // returns 1 and the result when the request yields one
    function automatic bit deframe_step(logic [7:0] b, logic fin, output out_item_t r);
        r = '0;
        case (phase)
            PH_EHDR: begin r = make_item(RK_ERROR, ERR_HEADER); return 1; end
            PH_EEOF: begin r = make_item(RK_ERROR, ERR_EOF); return 1; end
            PH_END: return 0;
            default: ;
        endcase
        if (fin)
        begin
            if (phase == PH_HDR && offset == 0)
                return 0;
            phase = PH_EEOF;
            r = make_item(RK_ERROR, ERR_EOF);
            return 1;
        end
        if (phase == PH_DAT)
        begin
            r = make_item(RK_DATA, ERR_NONE);
            r.data_byte = b;
            remaining = remaining - 1;
            if (remaining == 0)
            begin
                r.last_data = 1;
                phase = pad_cnt != 0 ? PH_PAD : PH_HDR;
            end
            return 1;
        end
        if (phase == PH_PAD)
        begin
            pad_cnt = pad_cnt - 1;
            if (pad_cnt == 0)
                phase = PH_HDR;
            return 0;
        end
        if (b != 0)
            nonzero = 1;
        if (phase == PH_HDR)
        begin
            if (offset == OFF_MODE || offset == OFF_SIZE)
                oct_state = 0;
            if (offset >= OFF_MODE && offset < OFF_MODE_END)
                parse_octal(b, 0);
            else if (offset >= OFF_SIZE && offset < OFF_SIZE_END)
                parse_octal(b, 1);
            else if (offset == OFF_TYPE)
                tflag = b;
            else if (offset == OFF_LINK)
                link = b != 0;
        end
        if (offset < OFF_LAST)
        begin
            offset++;
            return 0;
        end
        if (phase == PH_ZERO2)
        begin
            if (nonzero)
            begin
                phase = PH_EHDR;
                r = make_item(RK_ERROR, ERR_HEADER);
            end
            else
            begin
                phase = PH_END;
                r = make_item(RK_END, ERR_NONE);
            end
            clear_header();
            return 1;
        end
        if (!nonzero)
        begin
            phase = PH_ZERO2;
            clear_header();
            return 0;
        end
        if (bad)
        begin
            phase = PH_EHDR;
            clear_header();
            r = make_item(RK_ERROR, ERR_HEADER);
            return 1;
        end
        r = make_item(RK_HEADER, ERR_NONE);
        case (tflag)
            8'h00, "0": r.entry_kind = EK_REGULAR;
            "5": r.entry_kind = EK_DIR;
            "2": r.entry_kind = EK_SYMLINK;
            "1": r.entry_kind = EK_HARDLINK;
            default:
            begin
                r.entry_kind = EK_OTHER;
                r.other_kind_code = tflag;
            end
        endcase
        r.entry_size = size_acc;
        r.entry_mode = mode_acc;
        r.has_link_target = link;
        remaining = size_acc;
        pad_cnt = 9'(-size_acc);
        phase = remaining != 0 ? PH_DAT : (pad_cnt != 0 ? PH_PAD : PH_HDR);
        clear_header();
        return 1;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        row_t r;
        r.b = b; r.fin = 0; r.has_exp = 0; r.exp = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_end(bit has_exp, out_item_t e);
        row_t r;
        r.b = 8'($urandom); r.fin = 1; r.has_exp = has_exp; r.exp = e;
        plan.push_back(r);
    endfunction

    // type in the result that the newest row must give
    function automatic void expect_last(out_item_t e);
        plan[plan.size() - 1].has_exp = 1'b1;
        plan[plan.size() - 1].exp = e;
    endfunction

    // random filler for a noise byte in a header
    function automatic logic [7:0] fill_byte();
        return $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom);
    endfunction

    // write val with enough digits to hold it where the field allows
    function automatic void put_octal(ref logic [7:0] blk[512], input int at, input int len,
                                      input logic [63:0] val, input bit corrupt);
        int nd;
        int p;
        int need;
        need = 1;
        while (need < len && (val >> (3 * need)) != 0)
            need++;
        nd = $urandom_range(need, len);
        for (int i = 0; i < len; i++)
            blk[at + i] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
        p = at + $urandom_range(0, len - nd);
        for (int i = nd - 1; i >= 0; i--)
            blk[p + nd - 1 - i] = "0" + 8'((val >> (3 * i)) & 7);
        if (corrupt)
            blk[at + $urandom_range(0, len - 1)] = $urandom_range(0, 1) ? "8" : 8'($urandom);
    endfunction

    // one header block with noise outside the parsed fields
    function automatic void add_header(longint size, bit corrupt, logic [7:0] flag,
                                       bit wide_size);
        logic [7:0] blk[512];
        for (int i = 0; i < 512; i++)
            blk[i] = $urandom_range(0, 7) == 0 ? fill_byte() : 8'h00;
        blk[0] = 8'($urandom_range(1, 255));
        put_octal(blk, OFF_MODE, 8, 64'($urandom), corrupt && $urandom_range(0, 1));
        put_octal(blk, OFF_SIZE, 12, wide_size ? {$urandom, $urandom} : 64'(size),
                  corrupt);
        blk[OFF_TYPE] = flag;
        blk[OFF_LINK] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
        for (int i = 0; i < 512; i++)
            add_byte(blk[i]);
    endfunction

    function automatic void add_zero_block();
        for (int i = 0; i < 512; i++)
            add_byte(8'h00);
    endfunction

    function automatic logic [7:0] pick_flag();
        logic [7:0] flags[6] = '{8'h00, "0", "5", "2", "1", 8'h00};
        flags[5] = 8'($urandom);
        return flags[$urandom_range(0, 5)];
    endfunction

    // well-formed entry with data and padding; data bytes are random
    function automatic void add_entry(longint size);
        add_header(size, 0, pick_flag(), 0);
        for (longint i = 0; i < size; i++)
            add_byte(8'($urandom));
        for (longint i = 0; i < ((512 - size % 512) % 512); i++)
            add_byte(8'($urandom));
    endfunction

    task automatic build_plan();
        out_item_t e;
        int cut;
        // after reset an end at a block boundary is silent
        add_end(0, '0);
        // one random entry; its data run is long enough to back up the queue
        add_entry($urandom_range(0, 7) == 0 ? 512 : $urandom_range(8, 40));
        // close the archive: two zero blocks, or one of several truncations and header faults
        case ($urandom_range(0, 5))
            0:
            begin
                add_zero_block();
                add_zero_block();
                expect_last(make_item(RK_END, ERR_NONE));
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom));
                add_end(0, '0);
            end
            1:
            begin
                add_byte(8'hff);
                e = make_item(RK_ERROR, ERR_EOF);
                add_end(1, e);
                for (int i = 0; i < 3; i++)
                begin
                    add_byte(8'($urandom));
                    expect_last(e);
                end
            end
            2:
            begin
                add_zero_block();
                add_header(5, 0, "0", 0);
                e = make_item(RK_ERROR, ERR_HEADER);
                expect_last(e);
                add_byte(8'h11);
                expect_last(e);
            end
            3:
            begin
                add_header(0, 1, pick_flag(), $urandom_range(0, 1));
                repeat ($urandom_range(1, 5))
                    add_byte(8'($urandom));
                add_end(0, '0);
            end
            4:
            begin
                add_entry(40);
                cut = $urandom_range(1, 500);
                plan = plan[0:plan.size() - 1 - cut];
                add_end(0, '0);
                add_byte(8'h00);
            end
            default:
            begin
                add_entry(0);
                add_end(0, '0);
            end
        endcase
    endtask

    // sender
    initial
    begin
        deframer_reset();
        build_plan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        walk_plan();
    end

    task automatic walk_plan();
        for (int k = 0; k < plan.size(); k++)
            send(plan[k]);
        in_valid <= 1'b0;
        sending_done = 1'b1;
    endtask

    task automatic send(row_t r);
        out_item_t pred;
        in_item_t  item;
        bit any;
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.stream_byte = r.b;
        item.end_marker = r.fin;
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        any = deframe_step(r.b, r.fin, pred);
        if (phase == PH_DAT)
            data_started = 1'b1;
        if (r.has_exp && (!any || pred !== r.exp))
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: table %h model %h", r.exp, pred);
        end
        if (any)
            expected_q.push_back(pred);
    endtask

    // long receiver hold-off once data flows, so the block fills and stalls its input
    initial
    begin
        wait (data_started);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    // receiver stall pattern: mostly short holds, a few long ones
    initial
    begin
        int len;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(0, 19) == 0 ? $urandom_range(10, 40) :
                      $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= hold_off;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: kind %0d/%0d byte %h/%h last %b/%b",
                            want.result_kind, out_data.result_kind, want.data_byte,
                            out_data.data_byte, want.last_data, out_data.last_data,
                            " ek %0d/%0d oc %h/%h size %h/%h",
                            want.entry_kind, out_data.entry_kind, want.other_kind_code,
                            out_data.other_kind_code, want.entry_size, out_data.entry_size,
                            " mode %h/%h link %b/%b err %0d/%0d",
                            want.entry_mode, out_data.entry_mode, want.has_link_target,
                            out_data.has_link_target, want.error_code, out_data.error_code);
                end
            end
        end
    end

    initial
    begin
        wait (sending_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
